>>> rtl/core/assert_macros.svh
// Assertion macros shared by the RTL that checks itself.
// Each macro expects a clock named clk and an active-high reset named rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/core/pqlda_pkg.sv
// Shared types and constants for the PQ table-lookup distance accumulator.
// No dependencies; used by the top level, the table memory and the sum bank.
package pqlda_pkg;

  localparam int MAX_SUBSPACES_DEF = 64;
  localparam int BLOCK_POINTS_DEF  = 32;
  localparam int CENTROIDS_DEF     = 256;

  localparam int SUM_W  = 14;
  localparam int CFG_W  = 7;
  localparam int SUB_W  = 6;
  localparam int BYTE_W = 8;

  localparam logic [CFG_W-1:0] CFG_RESET = 7'd16;
  localparam logic [SUM_W-1:0] SUM_MAX   = '1;

  typedef enum logic {
    ACT_TABLE = 1'b0,
    ACT_CODE  = 1'b1
  } action_t;

  // Lookup table access for the item in the first stage.
  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } tab_ctl_t;

  // Accumulator bank accesses: read in stage one, write back in stage three.
  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic blk_end;
  } sum_ctl_t;

  // Reported by the sum bank when the last read of a block drain is issued.
  typedef struct packed {
    logic done;
    logic bank;
  } drain_stat_t;

endpackage

>>> rtl/core/pq_lut_distance_accumulate.sv
// Product-quantization distance scan: table fill, code lookup and per-point sums.
// Depends on pqlda_pkg, pqlda_table, pqlda_sums and assert_macros.svh.
//
//  channel | direction | handshake              | content
//  s_*     | in        | s_tvalid / s_tready    | table write or centroid code
//  m_*     | out       | m_tvalid / m_tready    | point distance, tlast on final point
//  cfg_*   | in        | cfg_valid / cfg_ready  | subspace_count
//
// One input item per cycle while s_tready is high. A code reaches its accumulator
// through address, table read, add and saturate, and write back.
// A finished block leaves at one distance per cycle while m_tready is high, from the
// sum bank's drain read port, as the next block fills the other bank; input stalls
// only while both banks wait to be drained. Reset clears counters, sums and sets
// subspace_count to 16; the table holds no defined value until written.
`include "assert_macros.svh"

module pq_lut_distance_accumulate #(
  parameter int MAX_SUBSPACES = pqlda_pkg::MAX_SUBSPACES_DEF,
  parameter int BLOCK_POINTS  = pqlda_pkg::BLOCK_POINTS_DEF,
  parameter int CENTROIDS     = pqlda_pkg::CENTROIDS_DEF,
  localparam int PT_W  = $clog2(BLOCK_POINTS),
  localparam int OUT_W = ((PT_W + pqlda_pkg::SUM_W + 7) / 8) * 8
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  // table_subspace[5:0], table_centroid[13:6], table_value[21:14], code[29:22]
  input  logic [31:0]                  s_tdata,
  // action[0]
  input  logic [0:0]                   s_tuser,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  // point_index[PT_W-1:0], distance[PT_W+13:PT_W]
  output logic [OUT_W-1:0]             m_tdata,
  output logic                         m_tlast,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [pqlda_pkg::CFG_W-1:0]  cfg_data
);
  import pqlda_pkg::*;

  localparam int SS_W      = (MAX_SUBSPACES > 1) ? $clog2(MAX_SUBSPACES) : 1;
  localparam int TAB_DEPTH = MAX_SUBSPACES * CENTROIDS;
  localparam int TA_W      = $clog2(TAB_DEPTH);
  localparam int CMP_W     = 10;

  logic [CFG_W-1:0]  subspace_count;
  logic [PT_W-1:0]   cur_point;
  logic [SS_W-1:0]   cur_sub;
  logic              acc_bank;
  logic [1:0]        busy;

  logic [SUB_W-1:0]  in_sub;
  logic [BYTE_W-1:0] in_cen;
  logic [BYTE_W-1:0] in_val;
  logic [BYTE_W-1:0] in_code;
  action_t           in_act;
  logic              acc;
  logic              is_code;
  logic              pt_last;
  logic [CMP_W-1:0]  sub_next;
  logic              sub_last;
  logic              blk_end;
  logic              wr_hit;
  logic              code_hit;
  logic [TA_W-1:0]   wr_addr;
  logic [TA_W-1:0]   rd_addr;

  logic              s1_valid;
  logic              s1_code;
  logic              s1_hit;
  logic [TA_W-1:0]   s1_addr;
  logic [BYTE_W-1:0] s1_wdata;
  logic [PT_W-1:0]   s1_point;
  logic              s1_bank;
  logic              s1_end;

  logic              s2_valid;
  logic              s2_hit;
  logic [PT_W-1:0]   s2_point;
  logic              s2_bank;
  logic              s2_end;

  logic              s3_valid;
  logic [SUM_W-1:0]  s3_sum;
  logic [PT_W-1:0]   s3_point;
  logic              s3_bank;
  logic              s3_end;

  tab_ctl_t          tab_ctl;
  sum_ctl_t          sum_ctl;
  drain_stat_t       drain_stat;
  logic [BYTE_W-1:0] tab_q;
  logic [SUM_W-1:0]  rd_sum;
  logic [BYTE_W-1:0] add;
  logic [SUM_W:0]    total;
  logic [SUM_W-1:0]  sat;

  assign in_sub  = s_tdata[5:0];
  assign in_cen  = s_tdata[13:6];
  assign in_val  = s_tdata[21:14];
  assign in_code = s_tdata[29:22];
  assign in_act  = action_t'(s_tuser[0]);

  assign cfg_ready = 1'b1;
  // A new block may only start filling a bank whose drain has finished.
  assign s_tready  = !busy[acc_bank];
  assign acc       = s_tvalid && s_tready;
  assign is_code   = (in_act == ACT_CODE);

  assign pt_last  = (cur_point == PT_W'(BLOCK_POINTS - 1));
  assign sub_next = CMP_W'(cur_sub) + 1'b1;
  // A count of zero behaves as one; a count above the table size is clipped.
  assign sub_last = (sub_next >= CMP_W'(subspace_count)) ||
                    (sub_next >= CMP_W'(MAX_SUBSPACES));
  assign blk_end  = pt_last && sub_last;

  assign wr_hit   = (CMP_W'(in_sub) < CMP_W'(MAX_SUBSPACES)) &&
                    (CMP_W'(in_cen) < CMP_W'(CENTROIDS));
  assign code_hit = (CMP_W'(in_code) < CMP_W'(CENTROIDS));
  assign wr_addr  = TA_W'(in_sub) * TA_W'(CENTROIDS) + TA_W'(in_cen);
  assign rd_addr  = TA_W'(cur_sub) * TA_W'(CENTROIDS) + TA_W'(in_code);

  always_ff @(posedge clk) begin
    if (rst) begin
      subspace_count <= CFG_RESET;
      cur_point      <= '0;
      cur_sub        <= '0;
      acc_bank       <= 1'b0;
      busy           <= '0;
      s1_valid       <= 1'b0;
      s2_valid       <= 1'b0;
      s3_valid       <= 1'b0;
    end else begin
      if (cfg_valid) begin
        subspace_count <= cfg_data;
      end
      if (drain_stat.done) begin
        busy[drain_stat.bank] <= 1'b0;
      end
      if (acc && is_code) begin
        if (pt_last) begin
          cur_point <= '0;
          if (sub_last) begin
            cur_sub        <= '0;
            busy[acc_bank] <= 1'b1;
            acc_bank       <= ~acc_bank;
          end else begin
            cur_sub <= cur_sub + 1'b1;
          end
        end else begin
          cur_point <= cur_point + 1'b1;
        end
      end
      s1_valid <= acc;
      s2_valid <= s1_valid && s1_code;
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    s1_code  <= is_code;
    s1_hit   <= is_code ? code_hit : wr_hit;
    s1_addr  <= is_code ? rd_addr : wr_addr;
    s1_wdata <= in_val;
    s1_point <= cur_point;
    s1_bank  <= acc_bank;
    s1_end   <= blk_end;

    s2_hit   <= s1_hit;
    s2_point <= s1_point;
    s2_bank  <= s1_bank;
    s2_end   <= s1_end;

    s3_sum   <= sat;
    s3_point <= s2_point;
    s3_bank  <= s2_bank;
    s3_end   <= s2_end;
  end

  assign tab_ctl.wr_en = s1_valid && !s1_code && s1_hit;
  assign tab_ctl.rd_en = s1_valid && s1_code;

  assign sum_ctl.rd_en   = s1_valid && s1_code;
  assign sum_ctl.wr_en   = s3_valid;
  assign sum_ctl.blk_end = s3_valid && s3_end;

  // Out-of-range codes add nothing; the sum saturates at the field maximum.
  assign add   = s2_hit ? tab_q : '0;
  assign total = {1'b0, rd_sum} + (SUM_W + 1)'(add);
  assign sat   = total[SUM_W] ? SUM_MAX : total[SUM_W-1:0];

  pqlda_table #(
    .DEPTH  (TAB_DEPTH),
    .ADDR_W (TA_W)
  ) u_table (
    .clk     (clk),
    .ctl     (tab_ctl),
    .addr    (s1_addr),
    .wr_data (s1_wdata),
    .rd_data (tab_q)
  );

  pqlda_sums #(
    .BLOCK_POINTS (BLOCK_POINTS),
    .PT_W         (PT_W),
    .OUT_W        (OUT_W)
  ) u_sums (
    .clk      (clk),
    .rst      (rst),
    .ctl      (sum_ctl),
    .rd_bank  (s1_bank),
    .rd_point (s1_point),
    .rd_sum   (rd_sum),
    .wr_bank  (s3_bank),
    .wr_point (s3_point),
    .wr_sum   (s3_sum),
    .stat     (drain_stat),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  `ASSERT_IMPLY(a_no_rmw_overlap, s2_valid && s3_valid, s2_point != s3_point, "read-modify-write overlap on one point")
  `ASSERT_IMPLY(a_wr_not_draining, s3_valid && drain_stat.done, s3_bank != drain_stat.bank, "write back into the bank being drained")
  `ASSERT_NEXT(a_busy_release, drain_stat.done, !busy[$past(drain_stat.bank)], "drained bank still marked busy")
  `ASSERT_IMPLY(a_last_point, m_tvalid && m_tlast, m_tdata[PT_W-1:0] == PT_W'(BLOCK_POINTS - 1), "tlast on a point other than the final one")

endmodule

>>> rtl/core/pqlda_table.sv
// Distance lookup table: one write or one registered read per cycle.
// Depends on pqlda_pkg for the access control type.
module pqlda_table #(
  parameter int DEPTH  = 16384,
  parameter int ADDR_W = 14
) (
  input  logic                   clk,
  input  pqlda_pkg::tab_ctl_t    ctl,
  input  logic [ADDR_W-1:0]      addr,
  input  logic [pqlda_pkg::BYTE_W-1:0] wr_data,
  output logic [pqlda_pkg::BYTE_W-1:0] rd_data
);
  import pqlda_pkg::*;

  logic [BYTE_W-1:0] mem [DEPTH];

  // Entries are undefined until written; no clearing is done.
  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[addr] <= wr_data;
    end
    if (ctl.rd_en) begin
      rd_data <= mem[addr];
    end
  end

endmodule

>>> rtl/core/pqlda_sums.sv
// Two banks of per-point accumulators with valid bits, plus the drain that streams
// a finished bank out one distance per cycle while m_tready is high. Depends on pqlda_pkg.
module pqlda_sums #(
  parameter int BLOCK_POINTS = 32,
  parameter int PT_W         = 5,
  parameter int OUT_W        = 24
) (
  input  logic                          clk,
  input  logic                          rst,
  input  pqlda_pkg::sum_ctl_t           ctl,
  input  logic                          rd_bank,
  input  logic [PT_W-1:0]               rd_point,
  output logic [pqlda_pkg::SUM_W-1:0]   rd_sum,
  input  logic                          wr_bank,
  input  logic [PT_W-1:0]               wr_point,
  input  logic [pqlda_pkg::SUM_W-1:0]   wr_sum,
  output pqlda_pkg::drain_stat_t        stat,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [OUT_W-1:0]              m_tdata,
  output logic                          m_tlast
);
  import pqlda_pkg::*;

  localparam int IDX_W     = PT_W + 1;
  localparam int SUM_DEPTH = 2 ** IDX_W;

  logic [SUM_W-1:0]     mem [SUM_DEPTH];
  logic [SUM_DEPTH-1:0] vbit;
  logic [1:0]           rdy;
  logic                 db;
  logic [PT_W-1:0]      cnt;

  logic [SUM_W-1:0]     acc_q;
  logic                 acc_vb;

  logic                 drv;
  logic [SUM_W-1:0]     dq;
  logic                 dvb;
  logic [PT_W-1:0]      dpt;
  logic                 dlast;

  logic                 ovld;
  logic [PT_W-1:0]      opt;
  logic [SUM_W-1:0]     odist;
  logic                 olast;

  logic [IDX_W-1:0]     rd_idx;
  logic [IDX_W-1:0]     wr_idx;
  logic [IDX_W-1:0]     dr_idx;
  logic                 oready;
  logic                 issue;
  logic                 cnt_last;

  assign rd_idx   = {rd_bank, rd_point};
  assign wr_idx   = {wr_bank, wr_point};
  assign dr_idx   = {db, cnt};
  assign oready   = !ovld || m_tready;
  // A drain read may go out while a finished bank is ready and the read stage will be free next cycle.
  assign issue    = rdy[db] && (!drv || oready);
  assign cnt_last = (cnt == PT_W'(BLOCK_POINTS - 1));

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_idx] <= wr_sum;
    end
    if (ctl.rd_en) begin
      acc_q  <= mem[rd_idx];
      acc_vb <= vbit[rd_idx];
    end
    if (issue) begin
      dq    <= mem[dr_idx];
      dvb   <= vbit[dr_idx];
      dpt   <= cnt;
      dlast <= cnt_last;
    end
    if (oready) begin
      opt   <= dpt;
      odist <= dvb ? dq : '0;
      olast <= dlast;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vbit <= '0;
      rdy  <= '0;
      db   <= 1'b0;
      cnt  <= '0;
      drv  <= 1'b0;
      ovld <= 1'b0;
    end else begin
      if (ctl.wr_en) begin
        vbit[wr_idx] <= 1'b1;
      end
      if (ctl.blk_end) begin
        rdy[wr_bank] <= 1'b1;
      end
      // Reading an entry out of the bank also returns it to zero.
      if (issue) begin
        vbit[dr_idx] <= 1'b0;
        if (cnt_last) begin
          cnt     <= '0;
          rdy[db] <= 1'b0;
          db      <= ~db;
        end else begin
          cnt <= cnt + 1'b1;
        end
      end
      if (issue) begin
        drv <= 1'b1;
      end else if (oready) begin
        drv <= 1'b0;
      end
      if (oready) begin
        ovld <= drv;
      end
    end
  end

  assign rd_sum    = acc_vb ? acc_q : '0;
  assign stat.done = issue && cnt_last;
  assign stat.bank = db;

  assign m_tvalid = ovld;
  assign m_tdata  = OUT_W'({odist, opt});
  assign m_tlast  = olast;

endmodule
